[hw/rtl/tpb_pkg.sv]
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared types and constants for the battery-compensated thrust-to-PWM core.
// ----------------------------------------------------------------------------
`default_nettype none

package tpb_pkg;

  localparam int unsigned NMOT   = 4;    // motors per beat
  localparam int unsigned CW     = 16;   // command width
  localparam int unsigned MVW    = 16;   // battery voltage width
  localparam int unsigned NW     = 11;   // pulse offset width
  localparam int unsigned RW     = 39;   // remainder width
  localparam int unsigned TW     = 26;   // clamped thrust width
  localparam int unsigned PW     = 12;   // pulse width field

  localparam logic [1:0]     ARM_ARMED   = 2'd2;
  localparam logic [MVW-1:0] VOLT_MIN    = 16'd1000;
  localparam logic [MVW-1:0] VOLT_SUBST  = 16'd11100;
  localparam logic [NW-1:0]  OFFSET_MAX  = 11'd1100;
  localparam logic [PW-1:0]  PWM_IDLE    = 12'd900;
  localparam logic [PW-1:0]  PWM_BASE    = 12'd1000;

  // Payload carried down the pipeline
  typedef struct packed {
    logic                      armed;
    logic [MVW-1:0]            mv;
    logic [NMOT-1:0][NW-1:0]   n;
    logic [NMOT-1:0][RW-1:0]   r;
  } pay_t;

endpackage

`default_nettype wire

[hw/rtl/tpb_front.sv]
// ----------------------------------------------------------------------------
// tpb_front
// Two front stages: thrust and voltage conditioning, then scaling of the
// thrust into the starting remainder of the offset search.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_front (
  input  wire logic                                 clk,
  input  wire logic                                 en0,
  input  wire logic                                 en1,
  input  wire logic [1:0]                           arm_state,
  input  wire logic [tpb_pkg::NMOT-1:0][tpb_pkg::CW-1:0] cmd,
  input  wire logic [tpb_pkg::MVW-1:0]              battery_mv,
  output tpb_pkg::pay_t                             pay_o
);

  tpb_pkg::pay_t s0_r, s0_nxt;
  tpb_pkg::pay_t s1_r, s1_nxt;

  // Stage 0: T = 1000*cmd + hover term, clamped at zero; voltage below VOLT_MIN becomes VOLT_SUBST
  always_comb begin
    logic signed [26:0] ts;
    s0_nxt       = '0;
    s0_nxt.armed = (arm_state == tpb_pkg::ARM_ARMED);
    s0_nxt.mv    = (battery_mv < tpb_pkg::VOLT_MIN) ? tpb_pkg::VOLT_SUBST : battery_mv;
    for (int k = 0; k < tpb_pkg::NMOT; k++) begin
      ts = $signed({{11{cmd[k][15]}}, cmd[k]}) * 27'sd1000 + 27'sd1668352;
      s0_nxt.r[k] = ts[26] ? '0 : tpb_pkg::RW'(ts[25:0]);
    end
  end

  // Stage 1: remainder = floor(T * 10^7 / 1024)
  always_comb begin
    logic [49:0] prod;
    s1_nxt = s0_r;
    for (int k = 0; k < tpb_pkg::NMOT; k++) begin
      prod = 50'(s0_r.r[k][tpb_pkg::TW-1:0]) * 50'd10000000;
      s1_nxt.r[k] = prod[48:10];
      s1_nxt.n[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) s0_r <= s0_nxt;
    if (en1) s1_r <= s1_nxt;
  end

  assign pay_o = s1_r;

endmodule

`default_nettype wire

[hw/rtl/tpb_step.sv]
// ----------------------------------------------------------------------------
// tpb_step
// One search stage: tries to set one bit of each motor's pulse offset.
// Uses q(n+d) - q(n) = d*(6n + 3d + 4000), so only one multiply per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_step #(
  parameter int unsigned BIT = 10
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire tpb_pkg::pay_t pay_i,
  output tpb_pkg::pay_t      pay_o
);

  tpb_pkg::pay_t pay_r, pay_nxt;

  always_comb begin
    logic [13:0]              kf;
    logic [29:0]              prod;
    logic [39:0]              sh;
    logic [tpb_pkg::NW-1:0]   cand;
    pay_nxt = pay_i;
    for (int k = 0; k < tpb_pkg::NMOT; k++) begin
      kf   = 14'(pay_i.n[k]) * 14'd6 + 14'(3 << BIT) + 14'd4000;
      prod = 30'(pay_i.mv) * 30'(kf);
      sh   = 40'(prod) << BIT;
      cand = pay_i.n[k] | tpb_pkg::NW'(1 << BIT);
      if ((cand <= tpb_pkg::OFFSET_MAX) && ({1'b0, pay_i.r[k]} >= sh)) begin
        pay_nxt.n[k] = cand;
        pay_nxt.r[k] = pay_i.r[k] - sh[tpb_pkg::RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) pay_r <= pay_nxt;
  end

  assign pay_o = pay_r;

endmodule

`default_nettype wire

[hw/rtl/thrust_to_pwm_battery_compensated_core.sv]
// ----------------------------------------------------------------------------
// thrust_to_pwm_battery_compensated_core
// Four-motor thrust to pulse width mapper with battery compensation.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_arm_state,       | beat in
//          | in_cmd_motor_0..3, in_battery_mv        |
//  out     | out_valid, out_stall, out_pwm_motor_0..3| beat out
//
//  Stages: two front stages, eleven offset search stages (one
//  bit each, one 16x14 multiply per motor), one output stage.
//  One beat per cycle sustained while out_stall is low; all four motors run in parallel lanes.
//  Synchronous active-low reset clears the valid bits only.
//  A stalled output holds; empty stages still fill so bubbles collapse.
// ----------------------------------------------------------------------------
`default_nettype none

module thrust_to_pwm_battery_compensated_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_arm_state,
  input  wire logic [15:0] in_cmd_motor_0,
  input  wire logic [15:0] in_cmd_motor_1,
  input  wire logic [15:0] in_cmd_motor_2,
  input  wire logic [15:0] in_cmd_motor_3,
  input  wire logic [15:0] in_battery_mv,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_pwm_motor_0,
  output logic [11:0]      out_pwm_motor_1,
  output logic [11:0]      out_pwm_motor_2,
  output logic [11:0]      out_pwm_motor_3
);

  localparam int unsigned NSTG = 14;

  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   en;
  tpb_pkg::pay_t   pay [0:11];
  logic [tpb_pkg::NMOT-1:0][tpb_pkg::PW-1:0] pwm_r, pwm_nxt;

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NSTG] = !out_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  tpb_front u_front (
    .clk        (clk),
    .en0        (en[0]),
    .en1        (en[1]),
    .arm_state  (in_arm_state),
    .cmd        ({in_cmd_motor_3, in_cmd_motor_2, in_cmd_motor_1, in_cmd_motor_0}),
    .battery_mv (in_battery_mv),
    .pay_o      (pay[0])
  );

  // Offset search, most significant bit first
  for (genvar g = 0; g < 11; g++) begin : g_step
    tpb_step #(.BIT(10 - g)) u_step (
      .clk   (clk),
      .en    (en[2+g]),
      .pay_i (pay[g]),
      .pay_o (pay[g+1])
    );
  end

  // Output stage: offset of 1100 lands exactly on the 2100 ceiling
  always_comb begin
    for (int k = 0; k < tpb_pkg::NMOT; k++) begin
      pwm_nxt[k] = pay[11].armed ? (tpb_pkg::PWM_BASE + tpb_pkg::PW'(pay[11].n[k]))
                                 : tpb_pkg::PWM_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) pwm_r <= pwm_nxt;
  end

  assign out_valid       = vld_r[NSTG-1];
  assign out_pwm_motor_0 = pwm_r[0];
  assign out_pwm_motor_1 = pwm_r[1];
  assign out_pwm_motor_2 = pwm_r[2];
  assign out_pwm_motor_3 = pwm_r[3];

  // Checks
  a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted beat not captured");

  a_drained_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NSTG-1] |-> !in_stall)
    else $error("input stalled with empty output stage");

  a_pwm_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pwm_motor_0 == tpb_pkg::PWM_IDLE ||
                   (out_pwm_motor_0 >= tpb_pkg::PWM_BASE && out_pwm_motor_0 <= 12'd2100)))
    else $error("pulse out of range");

endmodule

`default_nettype wire
